// ===== rtl/tpr_pkg.sv =====
package tpr_pkg;

  localparam int NET_W      = 14;
  localparam int CONF_W     = 3;
  localparam int MIN_W      = 8;
  localparam int POT_W      = 10;
  localparam int SEC_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int PROD_W     = 19;
  localparam int MAG_W      = PROD_W - 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int POT_FULL    = 1023;
  localparam int POT_SHIFT   = 10;
  localparam int SEC_LAST    = 59;
  localparam int STREAK_MAX  = 7;

  localparam logic [NET_W-1:0]  NETWORK_ID_RST    = NET_W'(2012);
  localparam logic [CONF_W-1:0] LEVEL_CONFIRM_RST = CONF_W'(3);
  localparam logic [CONF_W-1:0] STOP_CONFIRM_RST  = CONF_W'(5);
  localparam logic [MIN_W-1:0]  DURATION_MIN_RST  = MIN_W'(1);
  localparam logic [MIN_W-1:0]  DURATION_MAX_RST  = MIN_W'(180);
  localparam logic [MIN_W-1:0]  RUN_MINUTES_RST   = MIN_W'(30);

  typedef enum logic [1:0] {
    CMD_LEVEL,
    CMD_BUTTON,
    CMD_TICK,
    CMD_POT
  } cmd_t;

  typedef enum logic [1:0] {
    LVL_FULL,
    LVL_EMPTY,
    LVL_NORMAL,
    LVL_OTHER
  } level_t;

  typedef enum logic [2:0] {
    OP_DROP,
    OP_LEVEL,
    OP_BUTTON,
    OP_TICK,
    OP_POT
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FULL,
    ACT_EMPTY,
    ACT_SHOW,
    ACT_CLEAR
  } act_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_FULL,
    EV_EMPTY,
    EV_NORMAL,
    EV_STOPPED,
    EV_STARTED
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NETWORK_ID,
    REG_LEVEL_CONFIRM,
    REG_STOP_CONFIRM,
    REG_DURATION_MIN,
    REG_DURATION_MAX
  } cfg_reg_t;

  typedef struct packed {
    op_t                       op;
    level_t                    level;
    logic signed [PROD_W-1:0]  product;
  } q_entry_t;

  typedef struct packed {
    logic [CONF_W-1:0] level_confirm;
    logic [CONF_W-1:0] stop_confirm;
    logic [MIN_W-1:0]  duration_min;
  } back_cfg_t;

  function automatic logic [CONF_W-1:0] bump(input logic [CONF_W-1:0] s);
    return (s == CONF_W'(STREAK_MAX)) ? s : s + CONF_W'(1);
  endfunction

endpackage

// ===== rtl/tank_pump_run_controller.sv =====
// Tank pump run controller. Each transfer on the input channel carries one
// event (level message, button, one-second tick or potentiometer sample) and
// yields exactly one result transfer with the pump drive, accepted level,
// display request, event code and run setting. The block sustains one event
// per clock while out_ready stays high: a combinational front end classifies
// the event and forms the potentiometer product, a two-entry queue holds it,
// and the back end applies it to the run state and the result register. An
// event waits in a queue slot and its result is registered when the back end
// pops it. The user must write configuration registers through
// cfg_write/cfg_index/cfg_data only while no event is in flight; the block
// does not enforce this. Indexes beyond the last register are ignored.
module tank_pump_run_controller import tpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic                  frame_ok,
  input  logic [NET_W-1:0]      msg_network,
  input  logic [1:0]            level_code,
  input  logic [POT_W-1:0]      pot_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  pump_on,
  output logic [1:0]            level_state,
  output logic [2:0]            display_action,
  output logic [MIN_W-1:0]      display_number,
  output logic [2:0]            event_code,
  output logic [MIN_W-1:0]      run_minutes
);

  logic [NET_W-1:0]  network_id;
  logic [CONF_W-1:0] level_confirm;
  logic [CONF_W-1:0] stop_confirm;
  logic [MIN_W-1:0]  duration_min;
  logic [MIN_W-1:0]  duration_max;

  back_cfg_t back_cfg;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      q_push;
  logic      q_ready;
  logic      q_pop;
  logic      head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      network_id    <= NETWORK_ID_RST;
      level_confirm <= LEVEL_CONFIRM_RST;
      stop_confirm  <= STOP_CONFIRM_RST;
      duration_min  <= DURATION_MIN_RST;
      duration_max  <= DURATION_MAX_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NETWORK_ID:    network_id    <= cfg_data[NET_W-1:0];
        REG_LEVEL_CONFIRM: level_confirm <= cfg_data[CONF_W-1:0];
        REG_STOP_CONFIRM:  stop_confirm  <= cfg_data[CONF_W-1:0];
        REG_DURATION_MIN:  duration_min  <= cfg_data[MIN_W-1:0];
        REG_DURATION_MAX:  duration_max  <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.level_confirm = level_confirm;
  assign back_cfg.stop_confirm  = stop_confirm;
  assign back_cfg.duration_min  = duration_min;

  tpr_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .frame_ok     (frame_ok),
    .msg_network  (msg_network),
    .level_code   (level_code),
    .pot_sample   (pot_sample),
    .network_id   (network_id),
    .duration_min (duration_min),
    .duration_max (duration_max),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  tpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tpr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (back_cfg),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pump_on        (pump_on),
    .level_state    (level_state),
    .display_action (display_action),
    .display_number (display_number),
    .event_code     (event_code),
    .run_minutes    (run_minutes)
  );

endmodule

// ===== rtl/tpr_front.sv =====
module tpr_front import tpr_pkg::*; (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic              frame_ok,
  input  logic [NET_W-1:0]  msg_network,
  input  logic [1:0]        level_code,
  input  logic [POT_W-1:0]  pot_sample,
  input  logic [NET_W-1:0]  network_id,
  input  logic [MIN_W-1:0]  duration_min,
  input  logic [MIN_W-1:0]  duration_max,
  input  logic              q_ready,
  output logic              q_push,
  output q_entry_t          q_entry
);

  logic signed [MIN_W:0]  span;
  logic signed [PROD_W:0] prod_full;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // signed span times pot; the back end divides by full scale
  assign span      = $signed({1'b0, duration_max}) - $signed({1'b0, duration_min});
  assign prod_full = $signed({1'b0, pot_sample}) * span;

  always_comb begin
    q_entry.level   = level_t'(level_code);
    q_entry.product = prod_full[PROD_W-1:0];
    unique case (cmd_t'(command))
      CMD_LEVEL: begin
        // drop short frames and foreign networks here
        q_entry.op = (frame_ok && (msg_network == network_id)) ? OP_LEVEL : OP_DROP;
      end
      CMD_BUTTON: q_entry.op = OP_BUTTON;
      CMD_TICK:   q_entry.op = OP_TICK;
      CMD_POT:    q_entry.op = OP_POT;
      default:    q_entry.op = OP_DROP;
    endcase
  end

endmodule

// ===== rtl/tpr_queue.sv =====
module tpr_queue import tpr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     push_ready,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QDEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count != '0))
    else $error("queue count lost a transfer");

endmodule

// ===== rtl/tpr_back.sv =====
module tpr_back import tpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  back_cfg_t         cfg,
  input  logic              head_valid,
  input  q_entry_t          head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              pump_on,
  output logic [1:0]        level_state,
  output logic [2:0]        display_action,
  output logic [MIN_W-1:0]  display_number,
  output logic [2:0]        event_code,
  output logic [MIN_W-1:0]  run_minutes
);

  // run state
  logic              pump_running, pump_running_next;
  level_t            accepted_level, accepted_level_next;
  logic [CONF_W-1:0] full_streak, full_streak_next;
  logic [CONF_W-1:0] empty_streak, empty_streak_next;
  logic [CONF_W-1:0] normal_streak, normal_streak_next;
  logic [CONF_W-1:0] stop_streak, stop_streak_next;
  logic [MIN_W-1:0]  duration_minutes, duration_minutes_next;
  // remaining run time kept as whole minutes plus seconds
  logic [MIN_W-1:0]  mins_left, mins_left_next;
  logic [SEC_W-1:0]  secs_left, secs_left_next;

  // result register
  act_t              action_reg;
  logic [MIN_W-1:0]  number_reg;
  event_t            event_reg;
  act_t              action;
  logic [MIN_W-1:0]  number;
  event_t            event_val;

  // pot mapping: |product| / 1023 by shift-add estimate plus one correction
  logic [MAG_W-1:0]  mag;
  logic [MAG_W:0]    est_sum;
  logic [MAG_W-POT_SHIFT:0] est;
  logic [MAG_W+1:0]  est_mul;
  logic [MAG_W+1:0]  rem;
  logic [MAG_W-POT_SHIFT:0] quot;
  logic [MIN_W-1:0]  mapped;

  logic [CONF_W-1:0] bumped;
  logic              timer_spent;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    mag     = head.product[PROD_W-1] ? MAG_W'(-head.product) : head.product[MAG_W-1:0];
    est_sum = {1'b0, mag} + (MAG_W+1)'(mag >> POT_SHIFT);
    est     = est_sum[MAG_W:POT_SHIFT];
    est_mul = {1'b0, est, POT_SHIFT'(0)} - (MAG_W+2)'(est);
    rem     = {2'b0, mag} - est_mul;
    quot    = (rem >= (MAG_W+2)'(POT_FULL)) ? est + 1'b1 : est;
    mapped  = head.product[PROD_W-1] ? cfg.duration_min - quot[MIN_W-1:0]
                                     : cfg.duration_min + quot[MIN_W-1:0];
  end

  always_comb begin
    pump_running_next     = pump_running;
    accepted_level_next   = accepted_level;
    full_streak_next      = full_streak;
    empty_streak_next     = empty_streak;
    normal_streak_next    = normal_streak;
    stop_streak_next      = stop_streak;
    duration_minutes_next = duration_minutes;
    mins_left_next        = mins_left;
    secs_left_next        = secs_left;
    action                = ACT_NONE;
    number                = '0;
    event_val             = EV_NONE;
    bumped                = '0;
    timer_spent           = 1'b0;

    unique case (head.op)
      OP_LEVEL: begin
        full_streak_next   = '0;
        empty_streak_next  = '0;
        normal_streak_next = '0;
        unique case (head.level)
          LVL_FULL: begin
            action = ACT_FULL;
            bumped = bump(full_streak);
            full_streak_next = bumped;
            if (bumped >= cfg.level_confirm) begin
              pump_running_next   = 1'b0;
              mins_left_next      = duration_minutes;
              secs_left_next      = '0;
              full_streak_next    = '0;
              accepted_level_next = LVL_FULL;
              event_val           = EV_FULL;
            end
          end
          LVL_EMPTY: begin
            action = ACT_EMPTY;
            bumped = bump(empty_streak);
            empty_streak_next = bumped;
            if (bumped >= cfg.level_confirm) begin
              pump_running_next   = 1'b1;
              empty_streak_next   = '0;
              accepted_level_next = LVL_EMPTY;
              event_val           = EV_EMPTY;
            end
          end
          LVL_NORMAL: begin
            bumped = bump(normal_streak);
            normal_streak_next = bumped;
            if (bumped >= cfg.level_confirm) begin
              normal_streak_next  = '0;
              accepted_level_next = LVL_NORMAL;
              event_val           = EV_NORMAL;
            end
          end
          default: ;
        endcase
      end
      OP_BUTTON: begin
        if (!pump_running) begin
          pump_running_next = 1'b1;
          mins_left_next    = duration_minutes;
          secs_left_next    = '0;
          event_val         = EV_STARTED;
        end else begin
          pump_running_next = 1'b0;
          event_val         = EV_STOPPED;
        end
      end
      OP_TICK: begin
        if (pump_running) begin
          // count down one second, hold at zero
          if (secs_left != '0) begin
            secs_left_next = secs_left - SEC_W'(1);
          end else if (mins_left != '0) begin
            mins_left_next = mins_left - MIN_W'(1);
            secs_left_next = SEC_W'(SEC_LAST);
          end
          number = (mins_left_next == '1) ? mins_left_next : mins_left_next + MIN_W'(1);
          action = ACT_SHOW;
          timer_spent = (mins_left_next == '0) && (secs_left_next == '0);
          if (timer_spent || (accepted_level == LVL_FULL)) begin
            bumped = bump(stop_streak);
            stop_streak_next = bumped;
            if (bumped >= cfg.stop_confirm) begin
              pump_running_next = 1'b0;
              mins_left_next    = duration_minutes;
              secs_left_next    = '0;
              stop_streak_next  = '0;
              action            = ACT_CLEAR;
              number            = '0;
              event_val         = EV_STOPPED;
            end
          end else begin
            stop_streak_next = '0;
          end
        end
      end
      OP_POT: begin
        if (!pump_running && (mapped != duration_minutes)) begin
          duration_minutes_next = mapped;
          mins_left_next        = mapped;
          secs_left_next        = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_running     <= 1'b0;
      accepted_level   <= LVL_NORMAL;
      full_streak      <= '0;
      empty_streak     <= '0;
      normal_streak    <= '0;
      stop_streak      <= '0;
      duration_minutes <= RUN_MINUTES_RST;
      mins_left        <= RUN_MINUTES_RST;
      secs_left        <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        pump_running     <= pump_running_next;
        accepted_level   <= accepted_level_next;
        full_streak      <= full_streak_next;
        empty_streak     <= empty_streak_next;
        normal_streak    <= normal_streak_next;
        stop_streak      <= stop_streak_next;
        duration_minutes <= duration_minutes_next;
        mins_left        <= mins_left_next;
        secs_left        <= secs_left_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      action_reg  <= action;
      number_reg  <= number;
      event_reg   <= event_val;
    end
  end

  assign pump_on        = pump_running;
  assign level_state    = accepted_level;
  assign run_minutes    = duration_minutes;
  assign display_action = action_reg;
  assign display_number = number_reg;
  assign event_code     = event_reg;

  a_secs_range: assert property (@(posedge clk) disable iff (rst)
    secs_left <= SEC_W'(SEC_LAST))
    else $error("seconds field out of range");

  a_show_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action_reg == ACT_SHOW)) |-> (number_reg != '0))
    else $error("shown minutes zero");

  a_start_drives: assert property (@(posedge clk) disable iff (rst)
    (pop && (event_val == EV_STARTED)) |=> pump_running)
    else $error("start event without pump running");

  a_stop_drives: assert property (@(posedge clk) disable iff (rst)
    (pop && (event_val == EV_STOPPED)) |=> !pump_running)
    else $error("stop event with pump still running");

endmodule

// ===== bench/tank_pump_run_controller_test.sv =====
module tank_pump_run_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpr_pkg::*;

  localparam int SECS_PER_MIN = 60;
  localparam int NET_TOP      = 9999;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    cmd_t             cmd;
    logic             frame;
    logic [NET_W-1:0] net;
    level_t           code;
    logic [POT_W-1:0] pot;
  } pump_event_t;

  typedef struct packed {
    logic             pump;
    logic [1:0]       level;
    act_t             act;
    logic [MIN_W-1:0] number;
    event_t           ev;
    logic [MIN_W-1:0] minutes;
  } pump_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic frame_ok = 1'b0;
  logic [NET_W-1:0] msg_network = '0;
  logic [1:0] level_code = '0;
  logic [POT_W-1:0] pot_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pump_on;
  logic [1:0] level_state;
  logic [2:0] display_action;
  logic [MIN_W-1:0] display_number;
  logic [2:0] event_code;
  logic [MIN_W-1:0] run_minutes;

  tank_pump_run_controller dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .frame_ok(frame_ok), .msg_network(msg_network),
    .level_code(level_code), .pot_sample(pot_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .pump_on(pump_on), .level_state(level_state), .display_action(display_action),
    .display_number(display_number), .event_code(event_code), .run_minutes(run_minutes)
  );

  always #4 clk = ~clk;

  // controller settings as last written
  logic [NET_W-1:0]  set_net;
  logic [CONF_W-1:0] set_lconf, set_sconf;
  logic [MIN_W-1:0]  set_dmin, set_dmax;

  // predicted controller state
  logic             run_pump;
  level_t           acc_level;
  logic [CONF_W-1:0] full_run, empty_run, normal_run, stop_run;
  logic [MIN_W-1:0] run_min;
  logic [15:0]      secs_left;

  pump_event_t  events_to_send[$];
  pump_status_t status_due[$];
  int events_queued = 0;
  int status_seen = 0;
  int mismatches = 0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int stall_ask = 0;
  int stall_done = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold = 0;
  logic in_taken = 1'b0;

  function automatic logic [CONF_W-1:0] streak_up(input logic [CONF_W-1:0] s);
    return s + {{(CONF_W-1){1'b0}}, ~&s};
  endfunction

  function automatic void reload_timer();
    secs_left = 16'(run_min * SECS_PER_MIN);
  endfunction

  function automatic pump_status_t next_status(input pump_event_t it);
    pump_status_t st;
    int shown, span, mapped;
    logic [MIN_W-1:0] fresh;
    st.act = ACT_NONE;
    st.number = '0;
    st.ev = EV_NONE;
    case (it.cmd)
      CMD_LEVEL: begin
        if (it.frame && it.net == set_net) begin
          full_run   = (it.code == LVL_FULL)   ? streak_up(full_run)   : '0;
          empty_run  = (it.code == LVL_EMPTY)  ? streak_up(empty_run)  : '0;
          normal_run = (it.code == LVL_NORMAL) ? streak_up(normal_run) : '0;
          case (it.code)
            LVL_FULL: begin
              st.act = ACT_FULL;
              if (full_run >= set_lconf) begin
                run_pump = 1'b0;
                reload_timer();
                full_run = '0;
                acc_level = LVL_FULL;
                st.ev = EV_FULL;
              end
            end
            LVL_EMPTY: begin
              st.act = ACT_EMPTY;
              if (empty_run >= set_lconf) begin
                run_pump = 1'b1;
                empty_run = '0;
                acc_level = LVL_EMPTY;
                st.ev = EV_EMPTY;
              end
            end
            LVL_NORMAL: begin
              if (normal_run >= set_lconf) begin
                acc_level = LVL_NORMAL;
                normal_run = '0;
                st.ev = EV_NORMAL;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_BUTTON: begin
        if (!run_pump) begin
          run_pump = 1'b1;
          reload_timer();
          st.ev = EV_STARTED;
        end else begin
          run_pump = 1'b0;
          st.ev = EV_STOPPED;
        end
      end
      CMD_TICK: begin
        if (run_pump) begin
          // hold at zero, no wrap
          if (secs_left != 0) secs_left = secs_left - 16'd1;
          shown = secs_left / SECS_PER_MIN + 1;
          if (shown > 255) shown = 255;
          st.number = MIN_W'(shown);
          st.act = ACT_SHOW;
          if (secs_left == 0 || acc_level == LVL_FULL) begin
            stop_run = streak_up(stop_run);
            if (stop_run >= set_sconf) begin
              run_pump = 1'b0;
              reload_timer();
              stop_run = '0;
              st.act = ACT_CLEAR;
              st.number = '0;
              st.ev = EV_STOPPED;
            end
          end else begin
            stop_run = '0;
          end
        end
      end
      default: begin
        if (!run_pump) begin
          span = int'(set_dmax) - int'(set_dmin);
          mapped = int'(it.pot) * span / POT_FULL + int'(set_dmin);
          fresh = mapped[MIN_W-1:0];
          if (fresh != run_min) begin
            run_min = fresh;
            reload_timer();
          end
        end
      end
    endcase
    st.pump = run_pump;
    st.level = acc_level;
    st.minutes = run_min;
    return st;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // sender: hold the payload until its transfer, then maybe idle
  always @(negedge clk) begin : sender
    pump_event_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (in_valid && !in_taken) begin
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (events_to_send.size() > 0) begin
      nxt = events_to_send.pop_front();
      command <= nxt.cmd;
      frame_ok <= nxt.frame;
      msg_network <= nxt.net;
      level_code <= nxt.code;
      pot_sample <= nxt.pot;
      in_valid <= 1'b1;
      if (tx_idle_on && $urandom_range(0, 99) < 30) tx_gap <= idle_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random back-pressure plus the long hold-off on request
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (stall_done != stall_ask) begin
      out_ready <= 1'b0;
      rx_hold <= LONG_HOLD;
      stall_done <= stall_ask;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      rx_gap <= idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    pump_event_t seen;
    pump_status_t want;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      seen.cmd = cmd_t'(command);
      seen.frame = frame_ok;
      seen.net = msg_network;
      seen.code = level_t'(level_code);
      seen.pot = pot_sample;
      status_due.push_back(next_status(seen));
    end
    if (!rst && out_valid && out_ready) begin
      status_seen++;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none got event %0d",
                 $time, event_code);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("pump_on", want.pump, pump_on);
        check_field("level_state", want.level, level_state);
        check_field("display_action", want.act, display_action);
        check_field("display_number", want.number, display_number);
        check_field("event_code", want.ev, event_code);
        check_field("run_minutes", want.minutes, run_minutes);
      end
    end
  end

  function automatic logic [NET_W-1:0] foreign_net();
    return NET_W'((int'(set_net) + $urandom_range(1, NET_TOP)) % (NET_TOP + 1));
  endfunction

  function automatic pump_event_t make_event(input cmd_t c);
    pump_event_t e;
    e.cmd = c;
    e.frame = 1'($urandom);
    e.net = NET_W'($urandom_range(0, NET_TOP));
    e.code = level_t'($urandom_range(0, 3));
    e.pot = POT_W'($urandom_range(0, POT_FULL));
    if (c == CMD_LEVEL) begin
      e.frame = 1'b1;
      e.net = set_net;
    end
    return e;
  endfunction

  task automatic push(input pump_event_t e);
    events_to_send.push_back(e);
    events_queued++;
  endtask

  task automatic push_level(input level_t code, input int count);
    pump_event_t e;
    repeat (count) begin
      e = make_event(CMD_LEVEL);
      e.code = code;
      push(e);
    end
  endtask

  task automatic push_pot(input int value);
    pump_event_t e;
    e = make_event(CMD_POT);
    e.pot = POT_W'(value);
    push(e);
  endtask

  task automatic add_scenario();
    int r, sel;
    pump_event_t e;
    level_t code;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      sel = $urandom_range(0, 9);
      code = (sel < 3) ? LVL_FULL : (sel < 6) ? LVL_EMPTY : (sel < 9) ? LVL_NORMAL : LVL_OTHER;
      repeat ($urandom_range(1, int'(set_lconf) + 2)) begin
        e = make_event(CMD_LEVEL);
        e.code = code;
        // break the run now and then
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) != 0) e.frame = 1'b0;
          else e.net = foreign_net();
        end
        push(e);
      end
    end else if (r < 45) begin
      repeat ($urandom_range(1, 8)) push(make_event(CMD_TICK));
    end else if (r < 50) begin
      repeat ($urandom_range(40, 130)) push(make_event(CMD_TICK));
    end else if (r < 62) begin
      push(make_event(CMD_BUTTON));
    end else if (r < 77) begin
      e = make_event(CMD_POT);
      sel = $urandom_range(0, 9);
      if (sel == 0) e.pot = '0;
      else if (sel == 1) e.pot = '1;
      push(e);
    end else begin
      e = make_event(cmd_t'($urandom_range(0, 3)));
      e.frame = 1'($urandom);
      e.net = ($urandom_range(0, 2) == 0) ? set_net : NET_W'($urandom_range(0, NET_TOP));
      push(e);
    end
  endtask

  task automatic drain();
    while (status_seen != events_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input bit tx_on, input bit rx_on, input bit squeeze);
    int target;
    @(posedge clk);
    tx_idle_on = tx_on;
    rx_idle_on = rx_on;
    target = events_queued + count;
    while (events_queued < target) add_scenario();
    if (squeeze) stall_ask++;
    drain();
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    case (idx)
      REG_NETWORK_ID:    set_net = NET_W'(value);
      REG_LEVEL_CONFIRM: set_lconf = CONF_W'(value);
      REG_STOP_CONFIRM:  set_sconf = CONF_W'(value);
      REG_DURATION_MIN:  set_dmin = MIN_W'(value);
      REG_DURATION_MAX:  set_dmax = MIN_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_config(input int net, input int lc, input int sc, input int dmin,
                            input int dmax);
    write_reg(REG_NETWORK_ID, net);
    write_reg(REG_LEVEL_CONFIRM, lc);
    write_reg(REG_STOP_CONFIRM, sc);
    write_reg(REG_DURATION_MIN, dmin);
    write_reg(REG_DURATION_MAX, dmax);
  endtask

  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    pump_event_t e;
    set_net = NETWORK_ID_RST;
    set_lconf = LEVEL_CONFIRM_RST;
    set_sconf = STOP_CONFIRM_RST;
    set_dmin = DURATION_MIN_RST;
    set_dmax = DURATION_MAX_RST;
    run_pump = 1'b0;
    acc_level = LVL_NORMAL;
    full_run = '0;
    empty_run = '0;
    normal_run = '0;
    stop_run = '0;
    run_min = RUN_MINUTES_RST;
    secs_left = 16'(RUN_MINUTES_RST * SECS_PER_MIN);
    repeat (4) @(negedge clk);
    rst = 1'b0;

    @(posedge clk);
    push_pot(0);
    push_pot(POT_FULL);
    push_pot(512);
    e = make_event(CMD_LEVEL);
    e.code = LVL_FULL;
    e.frame = 1'b0;
    push(e);
    e.frame = 1'b1;
    e.net = NET_W'(NET_TOP);
    push(e);
    push_level(LVL_OTHER, 1);
    push_level(LVL_EMPTY, 3);
    push_pot(POT_FULL);
    push(make_event(CMD_TICK));
    push(make_event(CMD_TICK));
    push_level(LVL_FULL, 3);
    push(make_event(CMD_TICK));
    push_level(LVL_NORMAL, 3);
    push(make_event(CMD_BUTTON));
    push(make_event(CMD_TICK));
    push(make_event(CMD_BUTTON));
    e = make_event(CMD_LEVEL);
    e.net = '0;
    push(e);
    e.net = NET_W'(NET_TOP);
    e.code = LVL_OTHER;
    e.pot = '1;
    push(e);
    push(make_event(CMD_BUTTON));
    drain();

    run_phase(300, 1'b1, 1'b1, 1'b1);
    set_config(0, 1, 1, 1, 1);
    run_phase(315, 1'b1, 1'b1, 1'b0);
    set_config(NET_TOP, 7, 7, 255, 1);
    run_phase(315, 1'b0, 1'b0, 1'b0);
    set_config($urandom_range(0, NET_TOP), 0, 0, 1, 255);
    run_phase(315, 1'b1, 1'b1, 1'b0);
    set_config(2012, 2, 3, 1, 2);
    run_phase(315, 1'b1, 1'b1, 1'b1);
    set_config($urandom_range(0, NET_TOP), $urandom_range(1, 7), $urandom_range(1, 7),
               $urandom_range(1, 255), $urandom_range(1, 255));
    run_phase(315, 1'b1, 1'b0, 1'b0);

    repeat (8) @(negedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
